>>> sv/vmcp_pkg.sv
`timescale 1ns / 1ps
package vmcp_pkg;

  // Fraction bits of the fixed point format
  localparam int FRAC_BITS = 16;

  // Entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Field width of every fixed point value
  localparam int FIX_W = 32;

  // Width of the normalizing shift amount
  localparam int SHIFT_W = 5;

  // Classified pose handed from front to back
  typedef struct packed {
    logic [8:0][FIX_W-1:0]   r;      // rotation, row then column
    logic [2:0][FIX_W-1:0]   t;      // translation
    logic [2:0][FIX_W-1:0]   mag;    // magnitudes of the view direction
    logic [2:0]              neg;    // view direction component is negative
    logic [SHIFT_W-1:0]      shift;  // left shift that normalizes the magnitudes
    logic                    degen;  // view direction is zero
  } cls_t;

endpackage

>>> sv/vmcp_pose_if.sv
`timescale 1ns / 1ps
interface vmcp_pose_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  r00;
  logic signed [31:0]  r01;
  logic signed [31:0]  r02;
  logic signed [31:0]  r10;
  logic signed [31:0]  r11;
  logic signed [31:0]  r12;
  logic signed [31:0]  r20;
  logic signed [31:0]  r21;
  logic signed [31:0]  r22;
  logic signed [31:0]  trans_x;
  logic signed [31:0]  trans_y;
  logic signed [31:0]  trans_z;

  modport source (
    output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, trans_x, trans_y, trans_z,
    input  ready
  );
  modport sink (
    input  valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, trans_x, trans_y, trans_z,
    output ready
  );
endinterface

>>> sv/vmcp_cam_if.sv
`timescale 1ns / 1ps
interface vmcp_cam_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  eye_x;
  logic signed [31:0]  eye_y;
  logic signed [31:0]  eye_z;
  logic signed [31:0]  look_x;
  logic signed [31:0]  look_y;
  logic signed [31:0]  look_z;
  logic                degenerate;

  modport source (
    output valid, eye_x, eye_y, eye_z, look_x, look_y, look_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, eye_x, eye_y, eye_z, look_x, look_y, look_z, degenerate,
    output ready
  );
endinterface

>>> sv/vmcp_front.sv
`timescale 1ns / 1ps
module vmcp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  vmcp_pose_if.sink       pose_i,
  output vmcp_pkg::cls_t  cls_o,
  output logic            cls_valid_o,
  input  logic            cls_ready_i
);

  logic [8:0][31:0]                r;
  logic [2:0][31:0]                mag;
  logic [2:0]                      neg;
  logic [31:0]                     mag_max;
  logic [vmcp_pkg::SHIFT_W-1:0]    top_pos;
  logic [vmcp_pkg::SHIFT_W-1:0]    shift;
  vmcp_pkg::cls_t                  cls_d, cls_q;
  logic                            vld_q;
  logic                            take;

  assign r[0] = pose_i.r00;
  assign r[1] = pose_i.r01;
  assign r[2] = pose_i.r02;
  assign r[3] = pose_i.r10;
  assign r[4] = pose_i.r11;
  assign r[5] = pose_i.r12;
  assign r[6] = pose_i.r20;
  assign r[7] = pose_i.r21;
  assign r[8] = pose_i.r22;

  // Magnitude and sign of the view direction, which is the negated third row
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i] = !r[6+i][31] && (r[6+i] != 32'd0);
      mag[i] = r[6+i][31] ? (~r[6+i] + 32'd1) : r[6+i];
    end
  end

  // Largest magnitude and its top set bit
  always_comb begin
    mag_max = mag[0];
    if (mag[1] > mag_max) mag_max = mag[1];
    if (mag[2] > mag_max) mag_max = mag[2];
    top_pos = '0;
    for (int i = 0; i < 32; i++) begin
      if (mag_max[i]) top_pos = vmcp_pkg::SHIFT_W'(i);
    end
    shift = (top_pos >= 5'd30) ? 5'd0 : (5'd30 - top_pos);
  end

  // Assemble the classified record
  always_comb begin
    cls_d.r     = r;
    cls_d.t[0]  = pose_i.trans_x;
    cls_d.t[1]  = pose_i.trans_y;
    cls_d.t[2]  = pose_i.trans_z;
    cls_d.mag   = mag;
    cls_d.neg   = neg;
    cls_d.shift = shift;
    cls_d.degen = (mag_max == 32'd0);
  end

  // Hold one record until the queue takes it
  assign pose_i.ready = !vld_q || cls_ready_i;
  assign take         = pose_i.valid && pose_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pose_i.ready) begin
      vld_q <= pose_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cls_q <= cls_d;
    end
  end

  assign cls_o       = cls_q;
  assign cls_valid_o = vld_q;

endmodule

>>> sv/vmcp_fifo.sv
`timescale 1ns / 1ps
module vmcp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vmcp_pkg::cls_t  in_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output vmcp_pkg::cls_t  out_o,
  output logic            out_valid_o,
  input  logic            out_ready_i
);

  localparam int QD = vmcp_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  vmcp_pkg::cls_t  mem_q [QD];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != CW'(QD));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_o       = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + PW'(1);
      if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + PW'(1);
      if (push && !pop)      cnt_q <= cnt_q + CW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CW'(1);
    end
  end

  // Store the incoming record
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QD))
    else $error("queue count beyond depth");

endmodule

>>> sv/vmcp_back.sv
`timescale 1ns / 1ps
module vmcp_back #(
  parameter int FRAC_BITS = vmcp_pkg::FRAC_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vmcp_pkg::cls_t  cls_i,
  input  logic            cls_valid_i,
  output logic            cls_ready_o,
  vmcp_cam_if.source      cam_o
);

  localparam int F    = FRAC_BITS;
  localparam int EW   = 67 - F;        // eye width after rounding
  localparam int NW   = 33 + F;        // dividend width
  localparam int QW   = F + 1;         // quotient width
  localparam int SQ0  = 2;             // stage holding the sum of squares
  localparam int PREP = SQ0 + 33;      // stage holding the dividends
  localparam int DEND = PREP + F + 1;  // last divider stage
  localparam int OUT  = DEND + 1;      // output register

  localparam logic signed [66:0] HALF = 67'(1) << (F - 1);

  typedef struct packed {
    logic [2:0][EW-1:0]  eye;
    logic [2:0][31:0]    mag;
    logic [2:0]          neg;
    logic                degen;
  } carry_t;

  logic                 adv;
  logic [OUT:0]         vld_q;

  logic [2:0][31:0]     mag0_q, mag1_q;
  logic [2:0]           neg0_q, neg1_q;
  logic                 degen0_q, degen1_q;
  logic signed [63:0]   prod_q [3][3];
  logic [63:0]          sq1_q [3];
  logic signed [66:0]   esum1_q [3];
  logic signed [66:0]   esum_d [3];

  logic [63:0]          rem_q  [0:32];
  logic [31:0]          root_q [0:32];
  carry_t               carry_q [SQ0:DEND];

  logic [NW-1:0]        drem_q [0:F+1][3];
  logic [QW-1:0]        dq_q   [0:F+1][3];
  logic [31:0]          dl_q   [0:F+1];

  logic signed [QW:0]   u [3];
  logic [31:0]          eye_d [3];
  logic [31:0]          look_d [3];
  logic [2:0][31:0]     eye_q, look_q;
  logic                 degen_q;

  function automatic logic [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647)       return 32'h7fff_ffff;
    else if (v < -72'sd2147483648) return 32'h8000_0000;
    else                           return v[31:0];
  endfunction

  // Whole pipeline advances unless the output is held
  assign adv         = !vld_q[OUT] || cam_o.ready;
  assign cls_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[OUT-1:0], cls_valid_i};
    end
  end

  // Stage 0: eye products and normalized magnitudes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mag0_q[i] <= cls_i.mag[i] << cls_i.shift;
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= $signed(cls_i.r[i*3+j]) * $signed(cls_i.t[i]);
        end
      end
      neg0_q   <= cls_i.neg;
      degen0_q <= cls_i.degen;
    end
  end

  // Stage 1: squares and negated eye sums with rounding half
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      esum_d[j] = HALF;
      for (int i = 0; i < 3; i++) begin
        esum_d[j] = esum_d[j] - 67'(prod_q[i][j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq1_q[i]   <= mag0_q[i] * mag0_q[i];
        esum1_q[i] <= esum_d[i];
      end
      mag1_q   <= mag0_q;
      neg1_q   <= neg0_q;
      degen1_q <= degen0_q;
    end
  end

  // Stage 2: sum of squares and rounded eye
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0]  <= sq1_q[0] + sq1_q[1] + sq1_q[2];
      root_q[0] <= '0;
      for (int j = 0; j < 3; j++) begin
        carry_q[SQ0].eye[j] <= EW'(esum1_q[j] >>> F);
      end
      carry_q[SQ0].mag   <= mag1_q;
      carry_q[SQ0].neg   <= neg1_q;
      carry_q[SQ0].degen <= degen1_q;
    end
  end

  // Square root, one result bit per stage
  for (genvar n = 0; n < 32; n++) begin : g_sqrt
    localparam int K = 31 - n;
    logic [65:0] trial;
    logic        ge;
    assign trial = (66'(root_q[n]) << (K + 1)) | (66'd1 << (2 * K));
    assign ge    = 66'(rem_q[n]) >= trial;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[n+1]         <= ge ? 64'(66'(rem_q[n]) - trial) : rem_q[n];
        root_q[n+1]        <= ge ? (root_q[n] | (32'd1 << K)) : root_q[n];
        carry_q[SQ0+n+1]   <= carry_q[SQ0+n];
      end
    end
  end

  // Dividends with rounding half of the length
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        drem_q[0][i] <= NW'({carry_q[PREP-1].mag[i], {F{1'b0}}}) + NW'(root_q[32] >> 1);
        dq_q[0][i]   <= '0;
      end
      dl_q[0]       <= root_q[32];
      carry_q[PREP] <= carry_q[PREP-1];
    end
  end

  // Division by the length, one quotient bit per stage
  for (genvar n = 0; n <= F; n++) begin : g_div
    localparam int K = F - n;
    logic [NW-1:0] dsh;
    assign dsh = NW'(dl_q[n]) << K;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          if (drem_q[n][i] >= dsh) begin
            drem_q[n+1][i] <= drem_q[n][i] - dsh;
            dq_q[n+1][i]   <= dq_q[n][i] | (QW'(1) << K);
          end else begin
            drem_q[n+1][i] <= drem_q[n][i];
            dq_q[n+1][i]   <= dq_q[n][i];
          end
        end
        dl_q[n+1]          <= dl_q[n];
        carry_q[PREP+n+1]  <= carry_q[PREP+n];
      end
    end
  end

  // Signed unit direction, look point and saturation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (carry_q[DEND].degen) begin
        u[i] = '0;
      end else if (carry_q[DEND].neg[i]) begin
        u[i] = -$signed({1'b0, dq_q[F+1][i]});
      end else begin
        u[i] = $signed({1'b0, dq_q[F+1][i]});
      end
      eye_d[i]  = sat32(72'($signed(carry_q[DEND].eye[i])));
      look_d[i] = sat32(72'($signed(carry_q[DEND].eye[i])) + 72'(u[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        eye_q[i]  <= eye_d[i];
        look_q[i] <= look_d[i];
      end
      degen_q <= carry_q[DEND].degen;
    end
  end

  assign cam_o.valid      = vld_q[OUT];
  assign cam_o.eye_x      = eye_q[0];
  assign cam_o.eye_y      = eye_q[1];
  assign cam_o.eye_z      = eye_q[2];
  assign cam_o.look_x     = look_q[0];
  assign cam_o.look_y     = look_q[1];
  assign cam_o.look_z     = look_q[2];
  assign cam_o.degenerate = degen_q;

  a_degen_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cam_o.valid && cam_o.degenerate |->
      (cam_o.look_x == cam_o.eye_x) && (cam_o.look_y == cam_o.eye_y) &&
      (cam_o.look_z == cam_o.eye_z))
    else $error("degenerate pose with look point off the eye");

  a_len_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[PREP] && !carry_q[PREP].degen |-> dl_q[0][31:30] != 2'b00)
    else $error("length below normalized range");

  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DEND] && !carry_q[DEND].degen |->
      (dq_q[F+1][0] <= (QW'(1) << F)) && (dq_q[F+1][1] <= (QW'(1) << F)) &&
      (dq_q[F+1][2] <= (QW'(1) << F)))
    else $error("unit component above one");

endmodule

>>> sv/view_matrix_camera_pose.sv
`timescale 1ns / 1ps
// Channel   Role    Carries
// pose_i    sink    rotation r00..r22 and translation, signed fixed point
// cam_o     source  eye, look point and degenerate flag
//
// One pose per cycle sustained while cam_o is ready. A transfer on pose_i passes the
// front register, the queue and the back pipeline, with its 32-stage square root and
// FRAC_BITS + 1 stage divider, before a valid result appears on cam_o.
// Reset clears all valid flags and queue pointers; payload registers are not reset.
// A held cam_o freezes the back pipeline; the two-entry queue and the front
// register keep accepting until they fill.
module view_matrix_camera_pose #(
  parameter int FRAC_BITS = vmcp_pkg::FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vmcp_pose_if.sink   pose_i,
  vmcp_cam_if.source  cam_o
);

  vmcp_pkg::cls_t  front_cls, queue_cls;
  logic            front_valid, front_ready;
  logic            queue_valid, queue_ready;

  vmcp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pose_i      (pose_i),
    .cls_o       (front_cls),
    .cls_valid_o (front_valid),
    .cls_ready_i (front_ready)
  );

  vmcp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (front_cls),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .out_o       (queue_cls),
    .out_valid_o (queue_valid),
    .out_ready_i (queue_ready)
  );

  vmcp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (queue_cls),
    .cls_valid_i (queue_valid),
    .cls_ready_o (queue_ready),
    .cam_o       (cam_o)
  );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic signed [31:0] r [9];
    logic signed [31:0] t [3];
  } pose_t;

  typedef struct {
    logic signed [31:0] eye [3];
    logic signed [31:0] look [3];
    logic               degen;
  } cam_t;

  localparam int LATENCY = vmcp_pkg::FRAC_BITS + 39;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_LEN = 300;

  logic clk_i;
  logic rst_ni;
  vmcp_pose_if pose_bus ();
  vmcp_cam_if  cam_bus ();

  view_matrix_camera_pose dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pose_i (pose_bus.sink),
    .cam_o  (cam_bus.source)
  );

  pose_t  pending_poses [$];
  cam_t   expected_cams [$];
  int     send_idle_pct;
  int     recv_idle_pct;
  bit     hold_off_req;
  int     hold_off_count;
  bit     pose_sent;
  int     error_count = 0;
  longint cycle_count = 0;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  // floor of the square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // compute eye = -R^T t and look = eye + unit(-row2)
  function automatic cam_t predict_camera(pose_t p);
    cam_t           c;
    longint         eye [3];
    longint         unit [3];
    longint         acc;
    longint         d;
    longint unsigned mag [3];
    longint unsigned m, s, len, q;
    bit             neg [3];
    int             fb;
    fb = vmcp_pkg::FRAC_BITS;
    for (int j = 0; j < 3; j++) begin
      acc = 0;
      // exact sum fits in 66 bits at most: use shifted floor terms and a remainder
      begin
        longint          qsum;
        longint unsigned rem;
        longint          prod;
        qsum = 0;
        rem = 64'd1 << (fb - 1);
        for (int i = 0; i < 3; i++) begin
          prod = -longint'(p.r[i*3+j]) * longint'(p.t[i]);
          qsum += prod >>> fb;
          rem += longint'(prod) & ((64'd1 << fb) - 1);
        end
        acc = qsum + longint'(rem >> fb);
      end
      eye[j] = acc;
    end
    m = 0;
    for (int i = 0; i < 3; i++) begin
      d = -longint'(p.r[6+i]);
      neg[i] = d < 0;
      mag[i] = neg[i] ? -d : d;
      if (mag[i] > m) m = mag[i];
      unit[i] = 0;
    end
    c.degen = (m == 0);
    if (!c.degen) begin
      while (m < (64'd1 << 30)) begin
        m = m << 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      s = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
      len = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
        q = ((mag[i] << fb) + (len >> 1)) / len;
        unit[i] = neg[i] ? -longint'(q) : longint'(q);
      end
    end
    for (int j = 0; j < 3; j++) begin
      c.eye[j] = 32'(sat32(eye[j]));
      c.look[j] = 32'(sat32(eye[j] + unit[j]));
    end
    return c;
  endfunction

  function automatic logic signed [31:0] rand_fix();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 131072)) - 65536;
      3: return $signed($urandom_range(0, 511)) - 256;
      default: return $urandom;
    endcase
  endfunction

  function automatic pose_t make_pose(logic signed [31:0] rv, logic signed [31:0] tv);
    pose_t p;
    for (int i = 0; i < 9; i++) p.r[i] = rv;
    for (int i = 0; i < 3; i++) p.t[i] = tv;
    return p;
  endfunction

  // queue one pose for the driver and its expected camera
  task automatic push_pose(pose_t p);
    pending_poses.insert(pending_poses.size(), p);
    expected_cams.insert(expected_cams.size(), predict_camera(p));
  endtask

  // note each pose transfer and drop the pose that was taken
  always @(posedge clk_i) begin
    pose_sent <= rst_ni && pose_bus.valid && pose_bus.ready;
    if (rst_ni && pose_bus.valid && pose_bus.ready) void'(pending_poses.pop_front());
  end

  // drive pose transfers at the falling edge
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_bus.valid <= 1'b0;
      {pose_bus.r00, pose_bus.r01, pose_bus.r02} <= '0;
      {pose_bus.r10, pose_bus.r11, pose_bus.r12} <= '0;
      {pose_bus.r20, pose_bus.r21, pose_bus.r22} <= '0;
      {pose_bus.trans_x, pose_bus.trans_y, pose_bus.trans_z} <= '0;
    end else if (!pose_bus.valid || pose_sent) begin
      if (pending_poses.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        pose_bus.valid <= 1'b1;
        {pose_bus.r00, pose_bus.r01, pose_bus.r02} <=
          {pending_poses[0].r[0], pending_poses[0].r[1], pending_poses[0].r[2]};
        {pose_bus.r10, pose_bus.r11, pose_bus.r12} <=
          {pending_poses[0].r[3], pending_poses[0].r[4], pending_poses[0].r[5]};
        {pose_bus.r20, pose_bus.r21, pose_bus.r22} <=
          {pending_poses[0].r[6], pending_poses[0].r[7], pending_poses[0].r[8]};
        {pose_bus.trans_x, pose_bus.trans_y, pose_bus.trans_z} <=
          {pending_poses[0].t[0], pending_poses[0].t[1], pending_poses[0].t[2]};
      end else begin
        pose_bus.valid <= 1'b0;
      end
    end
  end

  // drive the result ready at the falling edge, with one long hold-off
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_bus.ready <= 1'b0;
      hold_off_count <= 0;
    end else if (hold_off_req && hold_off_count < HOLD_OFF_LEN) begin
      hold_off_count <= hold_off_count + 1;
      cam_bus.ready <= 1'b0;
    end else begin
      cam_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // check every result transfer at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && cam_bus.valid && cam_bus.ready) begin
      if (expected_cams.size() == 0) begin
        $display("%0t: unexpected result eye %0d %0d %0d", $time,
                 cam_bus.eye_x, cam_bus.eye_y, cam_bus.eye_z);
        error_count++;
      end else begin
        cam_t e;
        e = expected_cams.pop_front();
        if (cam_bus.eye_x !== e.eye[0] || cam_bus.eye_y !== e.eye[1]
            || cam_bus.eye_z !== e.eye[2] || cam_bus.look_x !== e.look[0]
            || cam_bus.look_y !== e.look[1] || cam_bus.look_z !== e.look[2]
            || cam_bus.degenerate !== e.degen) begin
          $display("%0t: mismatch expected eye %0d %0d %0d look %0d %0d %0d degen %0b",
                   $time, e.eye[0], e.eye[1], e.eye[2], e.look[0], e.look[1],
                   e.look[2], e.degen);
          $display("%0t:          actual   eye %0d %0d %0d look %0d %0d %0d degen %0b",
                   $time, cam_bus.eye_x, cam_bus.eye_y, cam_bus.eye_z, cam_bus.look_x,
                   cam_bus.look_y, cam_bus.look_z, cam_bus.degenerate);
          error_count++;
        end
      end
    end
  end

  // count cycles and stop on timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    pose_t p;
    logic signed [31:0] edge_vals [6];
    rst_ni = 1'b0;
    send_idle_pct = 14;
    recv_idle_pct = 54;
    hold_off_req = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, identity, zero direction, single-axis directions
    edge_vals = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 32'sh1, -32'sh1, 32'sh10000};
    foreach (edge_vals[a]) begin
      push_pose(make_pose(edge_vals[a], edge_vals[a]));
      push_pose(make_pose(edge_vals[a], edge_vals[(a + 1) % 6]));
    end
    p = make_pose(0, 32'sh12345);
    p.r[0] = 32'sh10000; p.r[4] = 32'sh10000; p.r[8] = 32'sh10000;
    push_pose(p);
    p.r[8] = 0;
    push_pose(p);
    for (int i = 0; i < 3; i++) begin
      p = make_pose(0, 32'sh7FFFFFFF);
      p.r[6+i] = 32'sh80000000;
      push_pose(p);
      p.r[6+i] = 32'sh1;
      push_pose(p);
    end

    // random poses in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      wait (pending_poses.size() == 0);
      @(negedge clk_i);
      send_idle_pct = (phase == 1) ? 54 : (phase == 2 ? 0 : 14);
      recv_idle_pct = (phase == 1) ? 14 : (phase == 2 ? 0 : 54);
      if (phase == 2) hold_off_req = 1'b1;
      for (int n = 0; n < 580; n++) begin
        for (int i = 0; i < 9; i++) p.r[i] = rand_fix();
        for (int i = 0; i < 3; i++) p.t[i] = rand_fix();
        if ($urandom_range(0, 9) == 0) begin
          p.r[6] = 0; p.r[7] = 0; p.r[8] = 0;
        end
        push_pose(p);
      end
    end

    wait (pending_poses.size() == 0 && expected_cams.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/vmcp_pkg.sv
sv/vmcp_pose_if.sv
sv/vmcp_cam_if.sv
sv/vmcp_front.sv
sv/vmcp_fifo.sv
sv/vmcp_back.sv
sv/view_matrix_camera_pose.sv
verif/testbench.sv
